>>> rtl/pfe_pkg.sv
// Package for the printf format engine: opcodes, characters and control structs.
package pfe_pkg;

  localparam logic [1:0] OP_FORMAT = 2'd0;
  localparam logic [1:0] OP_STRING = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // "(null)" with the first character in the top byte.
  localparam logic [47:0] NULL_TEXT = 48'h28_6E_75_6C_6C_29;

  localparam int WIDTH_BITS = 6;
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = 16;

  typedef enum logic [1:0] {NUM_NONE, NUM_DEC, NUM_HEX} num_mode_t;

  typedef struct packed {
    logic [15:0]           a_text;
    logic [1:0]            a_n;
    logic [7:0]            pad_char;
    logic [WIDTH_BITS-1:0] pad_n;
    logic [47:0]           b_text;
    logic [2:0]            b_n;
    num_mode_t             num_mode;
    logic                  upper;
    logic [63:0]           mag;
    logic [WIDTH_BITS-1:0] width;
    logic                  nul;
  } plan_t;

  typedef struct packed {
    logic load;
    logic dd_step;
    logic norm_step;
    logic pad_calc;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic dd_last;
    logic norm_done;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

>>> rtl/pfe_datapath.sv
// Datapath: digit conversion, emission segments, length counter and result register.
module pfe_datapath
  import pfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  plan_t       plan,
  output status_t     stat,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [31:0] out_position,
  output logic        stored,
  output logic [31:0] total_length,
  output logic        last
);

  logic [31:0]           buffer_size;
  logic [31:0]           count;
  logic [15:0]           a_text;
  logic [1:0]            a_n;
  logic [7:0]            pad_char;
  logic [WIDTH_BITS-1:0] pad_n;
  logic [47:0]           b_text;
  logic [2:0]            b_n;
  logic                  upper;
  logic [WIDTH_BITS-1:0] width;
  logic                  nul;
  logic [79:0]           dig;
  logic [63:0]           bin;
  logic [4:0]            ndig;
  logic [5:0]            dd_cnt;

  logic [79:0]           dig_adj;
  logic [WIDTH_BITS-1:0] used;
  logic [3:0]            nib;
  logic [7:0]            dig_char;
  logic                  sel_a, sel_pad, sel_b, sel_dig;
  logic [1:0]            a_left;
  logic [WIDTH_BITS-1:0] pad_left;
  logic [2:0]            b_left;
  logic [4:0]            dig_left;
  logic                  nul_left;
  logic [32:0]           pos_plus;

  // Add-3 correction of every BCD digit before the shift.
  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      dig_adj[k*4 +: 4] = (dig[k*4 +: 4] >= 4'd5) ? dig[k*4 +: 4] + 4'd3 : dig[k*4 +: 4];
    end
  end

  assign used = WIDTH_BITS'(ndig) + WIDTH_BITS'(a_n) + WIDTH_BITS'(b_n);
  assign nib  = dig[79:76];
  assign dig_char = (nib < 4'd10) ? CH_ZERO + {4'h0, nib}
                  : (upper ? CH_UPPER_A : CH_LOWER_A) + {4'h0, nib} - 8'd10;

  assign sel_a   = a_n != 2'd0;
  assign sel_pad = !sel_a && pad_n != '0;
  assign sel_b   = !sel_a && !sel_pad && b_n != 3'd0;
  assign sel_dig = !sel_a && !sel_pad && !sel_b && ndig != 5'd0;

  assign a_left   = a_n - {1'b0, sel_a};
  assign pad_left = pad_n - WIDTH_BITS'(sel_pad);
  assign b_left   = b_n - {2'b0, sel_b};
  assign dig_left = ndig - {4'b0, sel_dig};
  assign nul_left = nul && (sel_a || sel_pad || sel_b || sel_dig);

  assign pos_plus = {1'b0, count} + 33'd1;

  assign stat.dd_last   = dd_cnt == 6'd63;
  assign stat.norm_done = ndig <= 5'd1 || nib != 4'h0;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.emit_last = a_left == 2'd0 && pad_left == '0 && b_left == 3'd0
                       && dig_left == 5'd0 && !nul_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= 32'd128;
      count       <= 32'd0;
      out_valid   <= 1'b0;
      a_n         <= 2'd0;
      pad_n       <= '0;
      b_n         <= 3'd0;
      ndig        <= 5'd0;
      nul         <= 1'b0;
      dd_cnt      <= 6'd0;
    end else begin
      if (cfg_valid) begin
        buffer_size <= cfg_data;
      end
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        a_text   <= plan.a_text;
        a_n      <= plan.a_n;
        pad_char <= plan.pad_char;
        pad_n    <= plan.pad_n;
        b_text   <= plan.b_text;
        b_n      <= plan.b_n;
        upper    <= plan.upper;
        width    <= plan.width;
        nul      <= plan.nul;
        dd_cnt   <= 6'd0;
        bin      <= plan.mag;
        case (plan.num_mode)
          NUM_DEC: begin
            dig  <= '0;
            ndig <= 5'(DEC_DIGITS);
          end
          NUM_HEX: begin
            dig  <= {plan.mag, 16'h0};
            ndig <= 5'(HEX_DIGITS);
          end
          default: begin
            ndig <= 5'd0;
          end
        endcase
      end
      if (cmd.dd_step) begin
        {dig, bin} <= {dig_adj[78:0], bin, 1'b0};
        dd_cnt     <= dd_cnt + 6'd1;
      end
      if (cmd.norm_step) begin
        dig  <= {dig[75:0], 4'h0};
        ndig <= ndig - 5'd1;
      end
      if (cmd.pad_calc) begin
        pad_n <= (width > used) ? width - used : '0;
      end
      if (cmd.emit_step) begin
        last      <= stat.emit_last;
        if (!sel_a && !sel_pad && !sel_b && !sel_dig) begin
          // Terminator: written at the clamped position, then the count restarts.
          out_byte     <= CH_NUL;
          out_position <= (buffer_size == 32'd0) ? 32'd0
                        : (count < buffer_size) ? count : buffer_size - 32'd1;
          stored       <= buffer_size != 32'd0;
          total_length <= count;
          nul          <= 1'b0;
          count        <= 32'd0;
        end else begin
          out_position <= count;
          stored       <= pos_plus < {1'b0, buffer_size};
          total_length <= (count == 32'hFFFF_FFFF) ? count : pos_plus[31:0];
          count        <= (count == 32'hFFFF_FFFF) ? count : pos_plus[31:0];
          if (sel_a) begin
            out_byte <= a_text[15:8];
            a_text   <= {a_text[7:0], 8'h0};
          end else if (sel_pad) begin
            out_byte <= pad_char;
          end else if (sel_b) begin
            out_byte <= b_text[47:40];
            b_text   <= {b_text[39:0], 8'h0};
          end else begin
            out_byte <= dig_char;
            dig      <= {dig[75:0], 4'h0};
          end
          a_n   <= a_left;
          pad_n <= pad_left;
          b_n   <= b_left;
          ndig  <= dig_left;
        end
      end
    end
  end

endmodule

>>> rtl/pfe_control.sv
// Controller: format parser state and the sequencer of the datapath.
module pfe_control
  import pfe_pkg::*;
#(
  parameter int MAX_WIDTH = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_value,
  input  logic [63:0] arg_value,
  input  logic        arg_is_null,
  input  status_t     stat,
  output cmd_t        cmd,
  output plan_t       plan
);

  typedef enum logic [2:0] {
    PH_LITERAL, PH_PERCENT, PH_ZERO, PH_WIDTH, PH_LENGTH, PH_STRING
  } phase_t;

  typedef enum logic [2:0] {ST_IDLE, ST_DD, ST_NORM, ST_PAD, ST_EMIT} state_t;

  state_t                state;
  phase_t                phase, phase_next;
  logic                  pad_with_zero, pad_with_zero_next;
  logic [WIDTH_BITS-1:0] field_width, field_width_next;
  logic [1:0]            length_level, length_level_next;
  logic [31:0]           string_left, string_left_next;

  logic                  accept, has_output, digit, wide;
  phase_t                ph;
  logic [9:0]            width_acc;
  logic [63:0]           sval, uval;
  logic [7:0]            pc;

  assign accept   = in_valid && state == ST_IDLE;
  assign in_stall = state != ST_IDLE;
  assign digit    = char_value >= CH_ZERO && char_value <= CH_NINE;
  assign wide     = length_level != 2'd0;
  assign width_acc = 10'(field_width) * 10'd10 + 10'(char_value - CH_ZERO);
  assign sval = wide ? arg_value : {{32{arg_value[31]}}, arg_value[31:0]};
  assign uval = wide ? arg_value : {32'h0, arg_value[31:0]};
  assign pc   = pad_with_zero ? CH_ZERO : CH_SPACE;

  always_comb begin
    phase_next         = phase;
    pad_with_zero_next = pad_with_zero;
    field_width_next   = field_width;
    length_level_next  = length_level;
    string_left_next   = string_left;
    plan          = '0;
    plan.pad_char = pc;
    plan.num_mode = NUM_NONE;
    ph = phase;
    case (opcode)
      OP_FORMAT: begin
        if (phase == PH_STRING) begin
          ph = PH_LITERAL;
          string_left_next = 32'd0;
          phase_next = PH_LITERAL;
        end
        if (ph == PH_LITERAL) begin
          if (char_value == CH_PERCENT) begin
            phase_next = PH_PERCENT;
          end else begin
            plan.a_text = {char_value, 8'h0};
            plan.a_n    = 2'd1;
          end
        end else if (ph == PH_PERCENT && char_value == CH_PERCENT) begin
          plan.a_text = {CH_PERCENT, 8'h0};
          plan.a_n    = 2'd1;
          phase_next  = PH_LITERAL;
        end else if ((ph == PH_PERCENT || ph == PH_ZERO) && char_value == CH_ZERO) begin
          pad_with_zero_next = 1'b1;
          phase_next = PH_ZERO;
        end else if ((ph == PH_PERCENT || ph == PH_ZERO || ph == PH_WIDTH) && digit) begin
          field_width_next = (width_acc > 10'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                          : width_acc[WIDTH_BITS-1:0];
          phase_next = PH_WIDTH;
        end else if (char_value == CH_L) begin
          if (length_level != 2'd2) begin
            length_level_next = length_level + 2'd1;
          end
          phase_next = PH_LENGTH;
        end else begin
          // Conversion byte: the specification ends here.
          phase_next         = PH_LITERAL;
          pad_with_zero_next = 1'b0;
          field_width_next   = '0;
          length_level_next  = 2'd0;
          plan.width = field_width;
          case (char_value)
            CH_D, CH_I: begin
              plan.num_mode = NUM_DEC;
              plan.mag = sval[63] ? ~sval + 64'd1 : sval;
              if (sval[63]) begin
                if (pad_with_zero) begin
                  plan.a_text = {CH_MINUS, 8'h0};
                  plan.a_n    = 2'd1;
                end else begin
                  plan.b_text = {CH_MINUS, 40'h0};
                  plan.b_n    = 3'd1;
                end
              end
            end
            CH_U: begin
              plan.num_mode = NUM_DEC;
              plan.mag = uval;
            end
            CH_X, CH_UPPER_X: begin
              plan.num_mode = NUM_HEX;
              plan.mag   = uval;
              plan.upper = char_value == CH_UPPER_X;
            end
            CH_P: begin
              plan.num_mode = NUM_HEX;
              plan.mag    = arg_value;
              plan.width  = '0;
              plan.a_text = {CH_ZERO, CH_X};
              plan.a_n    = 2'd2;
            end
            CH_C: begin
              plan.a_text = {arg_value[7:0], 8'h0};
              plan.a_n    = 2'd1;
            end
            CH_S: begin
              if (arg_is_null) begin
                plan.pad_n  = (field_width > WIDTH_BITS'(6)) ? field_width - WIDTH_BITS'(6)
                                                             : '0;
                plan.b_text = NULL_TEXT;
                plan.b_n    = 3'd6;
              end else begin
                plan.pad_n = (arg_value < 64'(field_width))
                           ? field_width - arg_value[WIDTH_BITS-1:0] : '0;
                string_left_next = (arg_value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : arg_value[31:0];
                if (arg_value != 64'd0) begin
                  phase_next = PH_STRING;
                end
              end
            end
            default: begin
              plan.a_text = {CH_PERCENT, char_value};
              plan.a_n    = 2'd2;
            end
          endcase
        end
      end
      OP_STRING: begin
        if (phase == PH_STRING && string_left != 32'd0) begin
          plan.a_text = {char_value, 8'h0};
          plan.a_n    = 2'd1;
          string_left_next = string_left - 32'd1;
          if (string_left == 32'd1) begin
            phase_next = PH_LITERAL;
          end
        end
      end
      OP_END: begin
        if (phase != PH_LITERAL && phase != PH_STRING) begin
          plan.a_text = {CH_PERCENT, 8'h0};
          plan.a_n    = 2'd1;
        end
        plan.nul           = 1'b1;
        phase_next         = PH_LITERAL;
        pad_with_zero_next = 1'b0;
        field_width_next   = '0;
        length_level_next  = 2'd0;
        string_left_next   = 32'd0;
      end
      default: begin
      end
    endcase
  end

  assign has_output = plan.a_n != 2'd0 || plan.pad_n != '0 || plan.b_n != 3'd0
                   || plan.num_mode != NUM_NONE || plan.nul;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.load = accept && has_output;
      ST_DD:    cmd.dd_step = 1'b1;
      ST_NORM:  cmd.norm_step = !stat.norm_done;
      ST_PAD:   cmd.pad_calc = 1'b1;
      ST_EMIT:  cmd.emit_step = stat.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_LITERAL;
      pad_with_zero <= 1'b0;
      field_width   <= '0;
      length_level  <= 2'd0;
      string_left   <= 32'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase         <= phase_next;
            pad_with_zero <= pad_with_zero_next;
            field_width   <= field_width_next;
            length_level  <= length_level_next;
            string_left   <= string_left_next;
            if (has_output) begin
              case (plan.num_mode)
                NUM_DEC: state <= ST_DD;
                NUM_HEX: state <= ST_NORM;
                default: state <= ST_EMIT;
              endcase
            end
          end
        end
        ST_DD: begin
          if (stat.dd_last) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (stat.norm_done) begin
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.out_free && stat.emit_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/printf_format_engine.sv
// Top level of the printf format engine: controller, datapath and assertions.
// An item with no output leaves the engine idle; a text item emits one byte per cycle
// while the output is not stalled. Decimal conversions first run shift-and-add-3 binary
// to BCD conversion, and decimal or hex conversions then remove leading zeros and set padding.
// Items are taken one at a time: in_stall stays high until the last byte has been emitted.
// Synchronous reset clears parser state and the count; buffer_size returns to 128.
module printf_format_engine
  import pfe_pkg::*;
#(
  parameter int MAX_WIDTH = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_value,
  input  logic [63:0] arg_value,
  input  logic        arg_is_null,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [31:0] out_position,
  output logic        stored,
  output logic [31:0] total_length,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t stat;
  plan_t   plan;

  assign cfg_ready = 1'b1;

  pfe_control #(.MAX_WIDTH(MAX_WIDTH)) u_control (
    .clk, .rst, .in_valid, .in_stall, .opcode, .char_value, .arg_value, .arg_is_null,
    .stat, .cmd, .plan
  );

  pfe_datapath u_datapath (
    .clk, .rst, .cmd, .plan, .stat, .cfg_valid, .cfg_data,
    .out_valid, .out_stall, .out_byte, .out_position, .stored, .total_length, .last
  );

`ifndef ASSERT_OFF
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> (!out_valid || !out_stall)) else $error("emit into full register");
  a_mid_item_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall) else $error("idle before last transfer");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit_step)) else $error("result without emit");
`endif

endmodule
